/* sv/brfro_pkg.sv */
package brfro_pkg;

   localparam int DEPTH    = 1024;
   localparam int MAX_RUN  = 64;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int PTR_W    = ADDR_W + 1;
   localparam int LEN_W    = 7;
   localparam int COUNT_W  = 11;
   localparam int CMP_W    = (PTR_W > LEN_W) ? PTR_W : LEN_W;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_PEEK    = 2'd1,
      OP_DEQUEUE = 2'd2,
      OP_ERASE   = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_STREAM
   } state_type;

   typedef struct packed {
      logic [1:0]       operation;
      logic [LEN_W-1:0] length;
      logic [7:0]       data_byte;
      logic             last_of_run;
   } req_item_type;

   typedef struct packed {
      logic               status;
      logic [7:0]         read_byte;
      logic               byte_valid;
      logic               last;
      logic [COUNT_W-1:0] stored_count;
      logic [COUNT_W-1:0] free_count;
   } rsp_item_type;

   typedef struct packed {
      logic             write_en;
      logic             rp_advance;
      logic [LEN_W-1:0] rp_amount;
      logic             run_update;
      logic             run_open;
      logic             run_accepted;
      logic [LEN_W-1:0] run_left;
      logic             fetch_start;
      logic             fetch_en;
      logic             out_load;
      logic             out_byte;
      logic             out_status;
      logic             out_last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [PTR_W-1:0] stored;
      logic             run_open;
      logic             run_accepted;
      logic [LEN_W-1:0] run_left;
   } dp_status_type;

endpackage

/* sv/brfro_req_if.sv */
interface brfro_req_if;
   import brfro_pkg::*;

   logic         valid;
   logic         ready;
   req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

/* sv/brfro_rsp_if.sv */
interface brfro_rsp_if;
   import brfro_pkg::*;

   logic         valid;
   logic         ready;
   rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

/* sv/brfro_ctrl.sv */
module brfro_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_operation,
   input  logic [brfro_pkg::LEN_W-1:0]     req_length,
   input  logic                            req_last_of_run,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  brfro_pkg::dp_status_type        status,
   output brfro_pkg::ctrl_cmd_type         cmd
);
   import brfro_pkg::*;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] fetch_left_ff, fetch_left_in;
   logic             fetch_valid_ff, fetch_valid_in;
   logic             fetch_last_ff, fetch_last_in;
   logic             out_valid_ff, out_valid_in;

   logic             accept;
   logic             out_free;
   logic             fetch_go;
   logic             move;
   logic             start_stream;
   logic [CMP_W-1:0] len_c;
   logic [CMP_W-1:0] stored_c;
   logic [CMP_W-1:0] free_c;
   logic             len_ok_max;
   logic             enq_accepted;
   logic [LEN_W-1:0] enq_left;
   logic             enq_write;
   logic             read_fail;
   logic [LEN_W-1:0] erase_n;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign fetch_go  = (state_ff == ST_STREAM) && (fetch_left_ff != '0)
                      && (!fetch_valid_ff || out_free);
   assign move      = (state_ff == ST_STREAM) && fetch_valid_ff && out_free;

   assign len_c      = CMP_W'(req_length);
   assign stored_c   = CMP_W'(status.stored);
   assign free_c     = CMP_W'(DEPTH) - stored_c;
   assign len_ok_max = req_length <= LEN_W'(MAX_RUN);

   assign enq_accepted = status.run_open ? status.run_accepted
                                         : (len_ok_max && (len_c <= free_c));
   assign enq_left     = status.run_open ? status.run_left
                                         : (enq_accepted ? req_length : '0);
   assign enq_write    = enq_accepted && (enq_left != '0)
                         && (stored_c < CMP_W'(DEPTH));
   assign read_fail    = !len_ok_max || (len_c > stored_c);
   assign erase_n      = (len_c < stored_c) ? req_length : LEN_W'(status.stored);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_stream) state_in = ST_STREAM;
         end
         ST_STREAM: begin
            if ((fetch_left_ff == '0) && fetch_valid_ff && out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      req_ready     = 1'b0;
      start_stream  = 1'b0;
      fetch_left_in = fetch_left_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (accept) begin
               cmd.run_update = 1'b1;
               case (req_operation)
                  OP_ENQUEUE: begin
                     cmd.write_en     = enq_write;
                     cmd.run_open     = !req_last_of_run;
                     cmd.run_accepted = !req_last_of_run && enq_accepted;
                     cmd.run_left     = req_last_of_run ? '0
                                        : enq_left - LEN_W'(enq_write);
                     cmd.out_load     = req_last_of_run;
                     cmd.out_status   = !enq_accepted;
                     cmd.out_last     = 1'b1;
                  end
                  OP_ERASE: begin
                     cmd.rp_advance = 1'b1;
                     cmd.rp_amount  = erase_n;
                     cmd.out_load   = 1'b1;
                     cmd.out_last   = 1'b1;
                  end
                  default: begin
                     if (read_fail || (req_length == '0)) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = read_fail;
                        cmd.out_last   = 1'b1;
                     end else begin
                        start_stream    = 1'b1;
                        cmd.fetch_start = 1'b1;
                        fetch_left_in   = req_length;
                        cmd.rp_advance  = (req_operation == OP_DEQUEUE);
                        cmd.rp_amount   = req_length;
                     end
                  end
               endcase
            end
         end
         ST_STREAM: begin
            cmd.fetch_en = fetch_go;
            cmd.out_load = move;
            cmd.out_byte = 1'b1;
            cmd.out_last = fetch_last_ff;
            if (fetch_go) fetch_left_in = fetch_left_ff - LEN_W'(1);
         end
         default: ;
      endcase

      if (fetch_go) begin
         fetch_valid_in = 1'b1;
         fetch_last_in  = (fetch_left_ff == LEN_W'(1));
      end else if (move) begin
         fetch_valid_in = 1'b0;
         fetch_last_in  = 1'b0;
      end else begin
         fetch_valid_in = fetch_valid_ff;
         fetch_last_in  = fetch_last_ff;
      end

      if (cmd.out_load) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fetch_left_ff  <= '0;
         fetch_valid_ff <= 1'b0;
         fetch_last_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fetch_left_ff  <= fetch_left_in;
         fetch_valid_ff <= fetch_valid_in;
         fetch_last_ff  <= fetch_last_in;
         out_valid_ff   <= out_valid_in;
      end
   end

endmodule

/* sv/brfro_datapath.sv */
module brfro_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [7:0]                 req_data_byte,
   input  brfro_pkg::ctrl_cmd_type    cmd,
   output brfro_pkg::dp_status_type   status,
   output brfro_pkg::rsp_item_type    rsp_item
);
   import brfro_pkg::*;

   logic [7:0]        mem [DEPTH];
   logic [7:0]        mem_q_ff;
   logic [ADDR_W-1:0] fetch_addr_ff;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic              run_open_ff, run_open_in;
   logic              run_accepted_ff, run_accepted_in;
   logic [LEN_W-1:0]  run_left_ff, run_left_in;
   logic [PTR_W-1:0]  stored_in;
   logic [PTR_W-1:0]  free_in;
   rsp_item_type      out_ff;

   assign wp_in = cmd.write_en ? wp_ff + PTR_W'(1) : wp_ff;
   assign rp_in = cmd.rp_advance ? rp_ff + PTR_W'(cmd.rp_amount) : rp_ff;
   assign stored_in = wp_in - rp_in;
   assign free_in   = PTR_W'(DEPTH) - stored_in;

   assign run_open_in     = cmd.run_update ? cmd.run_open     : run_open_ff;
   assign run_accepted_in = cmd.run_update ? cmd.run_accepted : run_accepted_ff;
   assign run_left_in     = cmd.run_update ? cmd.run_left     : run_left_ff;

   assign status.stored       = wp_ff - rp_ff;
   assign status.run_open     = run_open_ff;
   assign status.run_accepted = run_accepted_ff;
   assign status.run_left     = run_left_ff;
   assign rsp_item            = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff           <= '0;
         rp_ff           <= '0;
         run_open_ff     <= 1'b0;
         run_accepted_ff <= 1'b0;
         run_left_ff     <= '0;
      end else begin
         wp_ff           <= wp_in;
         rp_ff           <= rp_in;
         run_open_ff     <= run_open_in;
         run_accepted_ff <= run_accepted_in;
         run_left_ff     <= run_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_en) mem[wp_ff[ADDR_W-1:0]] <= req_data_byte;
      if (cmd.fetch_en) mem_q_ff <= mem[fetch_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch_start) fetch_addr_ff <= rp_ff[ADDR_W-1:0];
      else if (cmd.fetch_en) fetch_addr_ff <= fetch_addr_ff + ADDR_W'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff.status       <= cmd.out_status;
         out_ff.read_byte    <= cmd.out_byte ? mem_q_ff : 8'd0;
         out_ff.byte_valid   <= cmd.out_byte;
         out_ff.last         <= cmd.out_last;
         out_ff.stored_count <= COUNT_W'(stored_in);
         out_ff.free_count   <= COUNT_W'(free_in);
      end
   end

endmodule

/* sv/byte_ring_fifo_run_ops_core.sv */
// Enqueue: one byte item per cycle while the output is free; a run's last item gives its
// status item in the cycle after acceptance. Erase, failed or empty reads: one result in
// the cycle after. Peek/dequeue of N bytes: first byte via fetch address, store read and
// output registers, then one byte per cycle unless stalled; next item after the last.
// Synchronous reset clears pointers, run state and handshakes; store contents undefined.
module byte_ring_fifo_run_ops_core (
   input  logic        clock,
   input  logic        reset,
   brfro_req_if.sink   req_chan,
   brfro_rsp_if.source rsp_chan
);
   import brfro_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   brfro_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_operation   (req_chan.item.operation),
      .req_length      (req_chan.item.length),
      .req_last_of_run (req_chan.item.last_of_run),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .status          (status),
      .cmd             (cmd)
   );

   brfro_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_data_byte (req_chan.item.data_byte),
      .cmd           (cmd),
      .status        (status),
      .rsp_item      (rsp_chan.item)
   );

endmodule

/* test/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import brfro_pkg::*;

   localparam int RANDOM_ITEMS   = 260;
   localparam int HOLD_OFF_LEN   = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int TAIL_CYCLES    = 20;

   logic clock;
   logic reset;

   brfro_req_if req_bus ();
   brfro_rsp_if rsp_bus ();

   byte_ring_fifo_run_ops_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // ring model
   logic [7:0]       ring_mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr;
   logic [PTR_W-1:0] rd_ptr;
   bit               run_open_m;
   bit               run_ok_m;
   int               run_left_m;

   rsp_item_type pending_rows [$];

   int errors;
   int items_sent;
   int rows_checked;
   int runs_rejected;
   int reads_failed;
   int burst_left;
   int hold_off_cycles;
   int hold_left;
   int stall_pct;
   int phase_left;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int ring_held();
      logic [PTR_W-1:0] d;
      d = wr_ptr - rd_ptr;
      return int'(d);
   endfunction

   function automatic req_item_type make_req(input op_type op, input int len, input int data,
                                             input bit last);
      req_item_type it;
      it.operation   = op;
      it.length      = LEN_W'(len);
      it.data_byte   = 8'(data);
      it.last_of_run = last;
      return it;
   endfunction

   task automatic push_row(input logic status, input logic [7:0] b, input logic valid,
                           input logic last);
      rsp_item_type row;
      int held;
      held             = ring_held();
      row.status       = status;
      row.read_byte    = b;
      row.byte_valid   = valid;
      row.last         = last;
      row.stored_count = COUNT_W'(held);
      row.free_count   = COUNT_W'(DEPTH - held);
      pending_rows.push_back(row);
   endtask

   task automatic ring_predict(input req_item_type it);
      op_type           op;
      int               len;
      int               held;
      int               take;
      logic [PTR_W-1:0] start;
      logic [PTR_W-1:0] p;
      op   = op_type'(it.operation);
      len  = int'(it.length);
      held = ring_held();
      if (op == OP_ENQUEUE) begin
         if (!run_open_m) begin
            run_open_m = 1'b1;
            run_ok_m   = (len <= MAX_RUN) && (len <= DEPTH - held);
            run_left_m = run_ok_m ? len : 0;
         end
         if (run_ok_m && run_left_m > 0 && held < DEPTH) begin
            ring_mem[wr_ptr[ADDR_W-1:0]] = it.data_byte;
            wr_ptr = wr_ptr + PTR_W'(1);
            run_left_m--;
         end
         if (it.last_of_run) begin
            if (!run_ok_m) runs_rejected++;
            push_row(!run_ok_m, 8'h00, 1'b0, 1'b1);
            run_open_m = 1'b0;
            run_ok_m   = 1'b0;
            run_left_m = 0;
         end
      end else begin
         // any other operation closes an open run silently
         run_open_m = 1'b0;
         run_ok_m   = 1'b0;
         run_left_m = 0;
         if (op == OP_ERASE) begin
            take   = (len < held) ? len : held;
            rd_ptr = rd_ptr + PTR_W'(take);
            push_row(1'b0, 8'h00, 1'b0, 1'b1);
         end else if (len > MAX_RUN || len > held) begin
            reads_failed++;
            push_row(1'b1, 8'h00, 1'b0, 1'b1);
         end else if (len == 0) begin
            push_row(1'b0, 8'h00, 1'b0, 1'b1);
         end else begin
            start = rd_ptr;
            if (op == OP_DEQUEUE) rd_ptr = rd_ptr + PTR_W'(len);
            for (int i = 0; i < len; i++) begin
               p = start + PTR_W'(i);
               push_row(1'b0, ring_mem[p[ADDR_W-1:0]], 1'b1, i == len - 1);
            end
         end
      end
   endtask

   task automatic send_item(input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.item  <= it;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      ring_predict(it);
      items_sent++;
   endtask

   task automatic send_op(input op_type op, input int len);
      send_item(make_req(op, len, $urandom_range(0, 255), 1'($urandom_range(0, 1))));
   endtask

   // length is only read on the first item, so later items carry noise there
   task automatic send_run(input int announced, input int count, input bit close);
      for (int i = 0; i < count; i++)
         send_item(make_req(OP_ENQUEUE, (i == 0) ? announced : $urandom_range(0, 127),
                            $urandom_range(0, 255), close && (i == count - 1)));
   endtask

   task automatic wait_rows_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_rows.size() != 0);
   endtask

   task automatic check_row(input rsp_item_type got);
      rsp_item_type want;
      if (pending_rows.size() == 0) begin
         $display("%0t: result item with nothing expected, actual %h", $time, got);
         errors++;
         return;
      end
      want = pending_rows.pop_front();
      rows_checked++;
      if (got.status !== want.status) begin
         $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
         errors++;
      end
      if (got.read_byte !== want.read_byte) begin
         $display("%0t: read_byte expected %h actual %h", $time, want.read_byte,
                  got.read_byte);
         errors++;
      end
      if (got.byte_valid !== want.byte_valid) begin
         $display("%0t: byte_valid expected %0d actual %0d", $time, want.byte_valid,
                  got.byte_valid);
         errors++;
      end
      if (got.last !== want.last) begin
         $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
         errors++;
      end
      if (got.stored_count !== want.stored_count) begin
         $display("%0t: stored_count expected %0d actual %0d", $time, want.stored_count,
                  got.stored_count);
         errors++;
      end
      if (got.free_count !== want.free_count) begin
         $display("%0t: free_count expected %0d actual %0d", $time, want.free_count,
                  got.free_count);
         errors++;
      end
   endtask

   task automatic test_directed_cases();
      send_item(make_req(OP_PEEK, 0, 8'h5A, 1'b1));
      send_item(make_req(OP_DEQUEUE, 1, 8'h00, 1'b0));
      send_item(make_req(OP_ERASE, 5, 8'hFF, 1'b1));
      send_item(make_req(OP_PEEK, 127, 8'hFF, 1'b0));
      send_item(make_req(OP_ENQUEUE, 3, 8'h00, 1'b0));
      send_item(make_req(OP_ENQUEUE, 127, 8'hFF, 1'b0));
      send_item(make_req(OP_ENQUEUE, 0, 8'hA5, 1'b1));
      send_item(make_req(OP_PEEK, 3, 8'h00, 1'b0));
      send_item(make_req(OP_DEQUEUE, 2, 8'h00, 1'b1));
      send_item(make_req(OP_PEEK, 1, 8'h00, 1'b0));
      // zero-length run
      send_item(make_req(OP_ENQUEUE, 0, 8'h11, 1'b1));
      // run longer than allowed is rejected
      send_item(make_req(OP_ENQUEUE, 65, 8'h22, 1'b0));
      send_item(make_req(OP_ENQUEUE, 0, 8'h33, 1'b1));
      // bytes beyond the announced length are dropped
      send_item(make_req(OP_ENQUEUE, 2, 8'h01, 1'b0));
      send_item(make_req(OP_ENQUEUE, 0, 8'h02, 1'b0));
      send_item(make_req(OP_ENQUEUE, 0, 8'h03, 1'b0));
      send_item(make_req(OP_ENQUEUE, 0, 8'h04, 1'b1));
      // run ending short keeps what it stored
      send_item(make_req(OP_ENQUEUE, 4, 8'h10, 1'b0));
      send_item(make_req(OP_ENQUEUE, 0, 8'h20, 1'b1));
      // open run closed by another operation
      send_item(make_req(OP_ENQUEUE, 3, 8'h30, 1'b0));
      send_item(make_req(OP_PEEK, 6, 8'h00, 1'b1));
      send_item(make_req(OP_DEQUEUE, 64, 8'h00, 1'b0));
      send_item(make_req(OP_ERASE, 127, 8'h00, 1'b0));
   endtask

   task automatic test_receiver_hold_off();
      send_run(MAX_RUN, MAX_RUN, 1'b1);
      wait_rows_drained();
      hold_off_cycles = HOLD_OFF_LEN;
      send_op(OP_PEEK, MAX_RUN);
      send_op(OP_DEQUEUE, 32);
      send_run(8, 8, 1'b1);
      send_op(OP_PEEK, 40);
      send_op(OP_ERASE, 127);
   endtask

   task automatic test_random_traffic();
      int first;
      int r;
      int n;
      int held;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         r    = $urandom_range(0, 99);
         held = ring_held();
         if (held > MAX_RUN) held = MAX_RUN;
         if (r < 40) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, MAX_RUN) : $urandom_range(0, 16);
            if (n == 0) send_run(0, 1, 1'b1);
            else send_run(n, n, 1'b1);
         end else if (r < 46) begin
            case ($urandom_range(0, 3))
               0: send_run($urandom_range(65, 127), $urandom_range(1, 4), 1'b1);
               1: begin
                  n = $urandom_range(0, 8);
                  send_run(n, n + $urandom_range(1, 3), 1'b1);
               end
               2: begin
                  n = $urandom_range(2, 10);
                  send_run(n, $urandom_range(1, n - 1), 1'b1);
               end
               default: begin
                  n = $urandom_range(1, 10);
                  send_run(n, $urandom_range(1, n), 1'b0);
               end
            endcase
         end else if (r < 78) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, held);
            send_op((r < 60) ? OP_PEEK : OP_DEQUEUE, n);
         end else if (r < 88) begin
            send_op(OP_ERASE, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                          : $urandom_range(0, 20));
         end else begin
            send_item(make_req(op_type'($urandom_range(0, 3)), $urandom_range(0, 127),
                               $urandom_range(0, 255), 1'($urandom_range(0, 1))));
         end
      end
   endtask

   // receiver: stall phases of random density, plus the long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      hold_left  = 0;
      stall_pct  = 0;
      phase_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_off_cycles > 0) begin
            hold_left       = hold_off_cycles - 1;
            hold_off_cycles = 0;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               phase_left = $urandom_range(20, 80);
               case ($urandom_range(0, 4))
                  0, 1: stall_pct = 0;
                  2:    stall_pct = 30;
                  3:    stall_pct = 60;
                  default: stall_pct = 85;
               endcase
            end
            phase_left--;
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_row(rsp_bus.item);
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no item moved for %0d cycles, %0d results outstanding", $time,
               WATCHDOG_LIMIT, pending_rows.size());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      errors          = 0;
      items_sent      = 0;
      rows_checked    = 0;
      runs_rejected   = 0;
      reads_failed    = 0;
      burst_left      = 0;
      hold_off_cycles = 0;
      wr_ptr          = '0;
      rd_ptr          = '0;
      run_open_m      = 1'b0;
      run_ok_m        = 1'b0;
      run_left_m      = 0;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.item  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      wait_rows_drained();
      test_receiver_hold_off();
      wait_rows_drained();
      test_random_traffic();
      wait_rows_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d request items sent, %0d result items checked, %0d runs rejected,",
               items_sent, rows_checked, runs_rejected);
      $display("%0d reads refused; covered empty buffer, odd runs, hold-off and random mixes",
               reads_failed);
      if (errors == 0 && pending_rows.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
